/* hdl/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PFP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfp assertion failed (same cycle)");

// next-cycle implication, disabled during reset
`define PFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfp assertion failed (next cycle)");

`endif

/* hdl/pfp_pkg.sv */
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types, codes and helpers of the page framebuffer plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfp_pkg;

  localparam int SCREEN_COLS_DEF = 128;
  localparam int SCREEN_ROWS_DEF = 64;

  typedef enum logic [2:0] {
    CMD_POINT  = 3'd0,
    CMD_RECT   = 3'd1,
    CMD_CIRCLE = 3'd2,
    CMD_SCREEN = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    PEN_ERASE   = 2'd0,
    PEN_SET     = 2'd1,
    PEN_INVERT  = 2'd2,
    PEN_INVALID = 2'd3
  } pen_t;

  typedef enum logic [1:0] {
    PH_STEP = 2'd0,
    PH_PTS  = 2'd1,
    PH_AXIS = 2'd2
  } phase_t;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_GEN  = 6'b000100,
    S_WR   = 6'b001000,
    S_RD   = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

  function automatic logic [7:0] pen_apply(input logic [7:0] data, input logic [7:0] mask,
                                           input logic [1:0] pen);
    logic [7:0] res;
    case (pen)
      PEN_ERASE: res = data & ~mask;
      PEN_SET:   res = data | mask;
      default:   res = data ^ mask;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/pfp_store.sv */
// ----------------------------------------------------------------------------
// pfp_store
// Frame store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire pfp_pkg::ram_ctl_t ctl,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [7:0]       wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic [7:0]            rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/page_framebuffer_plotter_top.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_plotter_top
// Monochrome page frame store with point, rectangle, circle, fill and read.
// ----------------------------------------------------------------------------
// Input channel: one beat carries a whole command (cmd, position, size,
// radius, pen, page). in_stall is high from acceptance until the result beat
// has been taken, so commands run one at a time.
// Output channel: one beat per command with status and read_byte; it is held
// in an output register while out_stall is high, and nothing new is accepted
// until it leaves.
// Access: every touched pixel or byte is a read-modify-write on the store,
// read in S_GEN and written back in S_WR; pixels that fall off screen are
// skipped without a store access. A rectangle touches each visible pixel, a
// whole-screen fill each store byte, and a circle alternates a midpoint
// decision step with its eight symmetric points, then does the four axis
// points. Rejected pens and unused codes go straight to the result beat.
// Reset: the PAGES*SCREEN_COLS store bytes (1024 at 128x64) are zeroed by a
// pass of one byte per cycle, while in_stall stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_plotter_top #(
  parameter int SCREEN_COLS = pfp_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = pfp_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] pos_x,
  input  wire logic [7:0] pos_y,
  input  wire logic [7:0] area_width,
  input  wire logic [7:0] area_height,
  input  wire logic [5:0] circle_radius,
  input  wire logic [1:0] pen_mode,
  input  wire logic [2:0] read_page,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            status,
  output logic [7:0]      read_byte
);

  localparam int PAGES = (SCREEN_ROWS + 7) / 8;
  localparam int DEPTH = PAGES * SCREEN_COLS;
  localparam int AW    = $clog2(DEPTH);

  pfp_pkg::state_t state, state_next;
  pfp_pkg::phase_t phase;

  logic [2:0]        cmd_r;
  logic [1:0]        pen_r;
  logic [7:0]        x0, y0;
  logic [2:0]        page_r;
  logic [5:0]        rad;
  logic [8:0]        xi, yi, xe, ye;
  logic signed [7:0] cx, cy;
  logic signed [11:0] d;
  logic [2:0]        pk;
  logic [AW-1:0]     clr_cnt, waddr;
  logic [7:0]        wmask, rdata;
  logic              last_r;

  logic signed [9:0] dx, dy, tx, ty, cxe, cye, re;
  logic              on_scr, tgt_ok, last;
  logic [AW-1:0]     taddr;
  logic [8:0]        rows_left, rx_end, ry_end, x_sum, y_sum;
  logic [7:0]        smask, tmask;
  logic              is_circle, is_grid;
  pfp_pkg::ram_ctl_t ctl;

  assign is_circle = (cmd_r == pfp_pkg::CMD_CIRCLE);
  assign is_grid   = (cmd_r == pfp_pkg::CMD_RECT) || (cmd_r == pfp_pkg::CMD_SCREEN);
  assign cxe = 10'(cx);
  assign cye = 10'(cy);
  assign re  = $signed({4'd0, rad});

  // offset of the current circle point from the centre
  always_comb begin
    dx = '0;
    dy = '0;
    if (is_circle && phase == pfp_pkg::PH_PTS) begin
      case (pk)
        3'd0:    begin dx = cxe;  dy = cye;  end
        3'd1:    begin dx = -cxe; dy = cye;  end
        3'd2:    begin dx = cxe;  dy = -cye; end
        3'd3:    begin dx = -cxe; dy = -cye; end
        3'd4:    begin dx = cye;  dy = cxe;  end
        3'd5:    begin dx = -cye; dy = cxe;  end
        3'd6:    begin dx = cye;  dy = -cxe; end
        default: begin dx = -cye; dy = -cxe; end
      endcase
    end else if (is_circle && phase == pfp_pkg::PH_AXIS) begin
      case (pk[1:0])
        2'd0:    begin dx = re;  dy = '0;  end
        2'd1:    begin dx = '0;  dy = re;  end
        2'd2:    begin dx = -re; dy = '0;  end
        default: begin dx = '0;  dy = -re; end
      endcase
    end
  end

  always_comb begin
    if (is_grid) begin
      tx = $signed({1'b0, xi});
      ty = $signed({1'b0, yi});
    end else if (cmd_r == pfp_pkg::CMD_READ) begin
      tx = $signed({2'b0, x0});
      ty = $signed({4'b0, page_r, 3'b000});
    end else begin
      tx = $signed({2'b0, x0}) + dx;
      ty = $signed({2'b0, y0}) + dy;
    end
  end

  assign on_scr = !tx[9] && !ty[9] && ($unsigned(tx) < 10'(SCREEN_COLS))
                  && ($unsigned(ty) < 10'(SCREEN_ROWS));
  assign tgt_ok = on_scr && !(is_circle && phase == pfp_pkg::PH_STEP);
  assign taddr  = AW'(32'(ty[7:3]) * 32'(SCREEN_COLS) + 32'(tx[7:0]));

  // partial last page keeps bits of missing rows untouched
  assign rows_left = 9'(SCREEN_ROWS) - yi;
  assign smask = (rows_left >= 9'd8) ? 8'hff : 8'((9'd1 << rows_left) - 9'd1);
  assign tmask = (cmd_r == pfp_pkg::CMD_SCREEN) ? smask : 8'(8'd1 << ty[2:0]);

  always_comb begin
    case (cmd_r)
      pfp_pkg::CMD_RECT:   last = (xi + 9'd1 == xe) && (yi + 9'd1 == ye);
      pfp_pkg::CMD_SCREEN: last = (xi == 9'(SCREEN_COLS - 1)) && (yi + 9'd8 >= 9'(SCREEN_ROWS));
      pfp_pkg::CMD_CIRCLE: last = (phase == pfp_pkg::PH_AXIS) && (pk == 3'd3);
      default:             last = 1'b1;
    endcase
  end

  // clipped rectangle end, exclusive
  assign x_sum  = {1'b0, pos_x} + {1'b0, area_width};
  assign y_sum  = {1'b0, pos_y} + {1'b0, area_height};
  assign rx_end = (x_sum > 9'(SCREEN_COLS)) ? 9'(SCREEN_COLS) : x_sum;
  assign ry_end = (y_sum > 9'(SCREEN_ROWS)) ? 9'(SCREEN_ROWS) : y_sum;

  always_comb begin
    state_next = state;
    case (state)
      pfp_pkg::S_CLR:  if (clr_cnt == AW'(DEPTH - 1)) state_next = pfp_pkg::S_IDLE;
      pfp_pkg::S_IDLE: begin
        if (in_valid) begin
          if (cmd == pfp_pkg::CMD_READ) begin
            state_next = pfp_pkg::S_GEN;
          end else if (cmd > pfp_pkg::CMD_SCREEN || pen_mode == pfp_pkg::PEN_INVALID) begin
            state_next = pfp_pkg::S_DONE;
          end else if (cmd == pfp_pkg::CMD_RECT
                       && ({1'b0, pos_x} >= rx_end || {1'b0, pos_y} >= ry_end)) begin
            state_next = pfp_pkg::S_DONE;
          end else begin
            state_next = pfp_pkg::S_GEN;
          end
        end
      end
      pfp_pkg::S_GEN: begin
        if (tgt_ok) begin
          state_next = (cmd_r == pfp_pkg::CMD_READ) ? pfp_pkg::S_RD : pfp_pkg::S_WR;
        end else if (last && !(is_circle && phase == pfp_pkg::PH_STEP)) begin
          state_next = pfp_pkg::S_DONE;
        end
      end
      pfp_pkg::S_WR:   state_next = last_r ? pfp_pkg::S_DONE : pfp_pkg::S_GEN;
      pfp_pkg::S_RD:   state_next = pfp_pkg::S_DONE;
      pfp_pkg::S_DONE: if (!out_stall) state_next = pfp_pkg::S_IDLE;
      default:         state_next = pfp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pfp_pkg::S_CLR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == pfp_pkg::S_CLR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pfp_pkg::S_IDLE: begin
        cmd_r     <= cmd;
        pen_r     <= pen_mode;
        x0        <= pos_x;
        y0        <= pos_y;
        page_r    <= read_page;
        rad       <= circle_radius;
        status    <= (cmd <= pfp_pkg::CMD_SCREEN) && (pen_mode == pfp_pkg::PEN_INVALID);
        read_byte <= '0;
        xe        <= rx_end;
        ye        <= ry_end;
        cx        <= '0;
        cy        <= 8'(circle_radius);
        d         <= 12'sd1 - 12'(circle_radius);
        phase     <= pfp_pkg::PH_STEP;
        pk        <= '0;
        if (cmd == pfp_pkg::CMD_RECT) begin
          xi <= {1'b0, pos_x};
          yi <= {1'b0, pos_y};
        end else begin
          xi <= '0;
          yi <= '0;
        end
      end
      pfp_pkg::S_GEN: begin
        if (is_circle && phase == pfp_pkg::PH_STEP) begin
          // midpoint decision update
          if (d[11]) begin
            d <= d + 12'(cxe) + 12'(cxe) + 12'sd3;
          end else begin
            d  <= d + 12'(cxe) + 12'(cxe) - 12'(cye) - 12'(cye) + 12'sd5;
            cy <= cy - 8'sd1;
          end
          cx    <= cx + 8'sd1;
          phase <= pfp_pkg::PH_PTS;
          pk    <= '0;
        end else begin
          waddr  <= taddr;
          wmask  <= tmask;
          last_r <= last;
          case (cmd_r)
            pfp_pkg::CMD_RECT: begin
              if (yi + 9'd1 == ye) begin
                yi <= {1'b0, y0};
                xi <= xi + 9'd1;
              end else begin
                yi <= yi + 9'd1;
              end
            end
            pfp_pkg::CMD_SCREEN: begin
              if (xi == 9'(SCREEN_COLS - 1)) begin
                xi <= '0;
                yi <= yi + 9'd8;
              end else begin
                xi <= xi + 9'd1;
              end
            end
            pfp_pkg::CMD_CIRCLE: begin
              pk <= pk + 3'd1;
              if (phase == pfp_pkg::PH_PTS && pk == 3'd7) begin
                phase <= (cx < cy) ? pfp_pkg::PH_STEP : pfp_pkg::PH_AXIS;
              end
            end
            default: ;
          endcase
        end
      end
      pfp_pkg::S_RD: read_byte <= rdata;
      default: ;
    endcase
  end

  assign ctl.we = (state == pfp_pkg::S_WR) || (state == pfp_pkg::S_CLR);
  assign ctl.re = (state == pfp_pkg::S_GEN) && tgt_ok;

  pfp_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (ctl),
    .waddr ((state == pfp_pkg::S_CLR) ? clr_cnt : waddr),
    .wdata ((state == pfp_pkg::S_CLR) ? 8'h00 : pfp_pkg::pen_apply(rdata, wmask, pen_r)),
    .raddr (taddr),
    .rdata (rdata)
  );

  assign in_stall  = (state != pfp_pkg::S_IDLE);
  assign out_valid = (state == pfp_pkg::S_DONE);

endmodule

`default_nettype wire

/* hdl/pfp_checker.sv */
// ----------------------------------------------------------------------------
// pfp_checker
// Port-level checks of the plotter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pfp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       status,
  input wire logic [7:0] read_byte
);

  // a command keeps the input side busy until its beat is out
  `PFP_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `PFP_ASSERT_IMPL(a_no_accept_with_result, clk, rst, out_valid, in_stall)
  `PFP_ASSERT_IMPL(a_reject_zero_byte, clk, rst, out_valid && status, read_byte == 8'd0)
  // exactly one result beat per command
  `PFP_ASSERT_NEXT(a_result_once, clk, rst, out_valid && !out_stall, !out_valid)
  `PFP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(status) && $stable(read_byte))

endmodule

bind page_framebuffer_plotter_top pfp_checker u_chk (.*);

`default_nettype wire
